>>> hw/rtl/assert_macros.svh
// Assertion shorthands used by the checker file ytr_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/ytr_pkg.sv
package ytr_pkg;

	localparam int CFG_W = 13;
	localparam int SUM_W = 20;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [CFG_W-1:0] HD_WIDTH     = 13'd1280;
	localparam logic [CFG_W-1:0] HD_HEIGHT    = 13'd720;

	localparam logic [7:0] LUMA_OFFSET = 8'd16;
	localparam logic signed [8:0] CHROMA_MID = 9'sd128;

	localparam logic signed [SUM_W-1:0] LUMA_GAIN  = 20'sd298;
	localparam logic signed [SUM_W-1:0] ROUND_HALF = 20'sd128;

	localparam logic signed [SUM_W-1:0] RV_601 = 20'sd409;
	localparam logic signed [SUM_W-1:0] GU_601 = 20'sd100;
	localparam logic signed [SUM_W-1:0] GV_601 = 20'sd208;
	localparam logic signed [SUM_W-1:0] BU_601 = 20'sd516;
	localparam logic signed [SUM_W-1:0] RV_709 = 20'sd459;
	localparam logic signed [SUM_W-1:0] GU_709 = 20'sd55;
	localparam logic signed [SUM_W-1:0] GV_709 = 20'sd136;
	localparam logic signed [SUM_W-1:0] BU_709 = 20'sd541;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] luma_first;
		logic [7:0] chroma_blue;
		logic [7:0] luma_second;
		logic [7:0] chroma_red;
	} yuyv_word_t;

	typedef struct packed {
		logic [7:0] red_first;
		logic [7:0] green_first;
		logic [7:0] blue_first;
		logic [7:0] red_second;
		logic [7:0] green_second;
		logic [7:0] blue_second;
		logic       frame_end;
	} rgb_word_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// floor shift by 8 then clamp to 0..255
	function automatic logic [7:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
		logic [7:0] res;
		if (sum[SUM_W-1]) begin
			res = 8'd0;
		end else if (|sum[SUM_W-2:16]) begin
			res = 8'd255;
		end else begin
			res = sum[15:8];
		end
		return res;
	endfunction

endpackage

>>> hw/rtl/ytr_stream_if.sv
interface ytr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/ytr_pixel.sv
module ytr_pixel (
	input  logic [7:0]                          y,
	input  logic signed [8:0]                   d,
	input  logic signed [8:0]                   e,
	input  logic                                hd,
	output ytr_pkg::rgb_t                       rgb
);
	logic [7:0] c;
	logic signed [ytr_pkg::SUM_W-1:0] y_term;
	logic signed [ytr_pkg::SUM_W-1:0] d_ext;
	logic signed [ytr_pkg::SUM_W-1:0] e_ext;
	logic signed [ytr_pkg::SUM_W-1:0] rv;
	logic signed [ytr_pkg::SUM_W-1:0] gu;
	logic signed [ytr_pkg::SUM_W-1:0] gv;
	logic signed [ytr_pkg::SUM_W-1:0] bu;
	logic signed [ytr_pkg::SUM_W-1:0] sum_r;
	logic signed [ytr_pkg::SUM_W-1:0] sum_g;
	logic signed [ytr_pkg::SUM_W-1:0] sum_b;

	always_comb begin
		c      = (y > ytr_pkg::LUMA_OFFSET) ? (y - ytr_pkg::LUMA_OFFSET) : 8'd0;
		y_term = ytr_pkg::SUM_W'($signed({1'b0, c})) * ytr_pkg::LUMA_GAIN;
		d_ext  = ytr_pkg::SUM_W'(d);
		e_ext  = ytr_pkg::SUM_W'(e);
		rv     = hd ? ytr_pkg::RV_709 : ytr_pkg::RV_601;
		gu     = hd ? ytr_pkg::GU_709 : ytr_pkg::GU_601;
		gv     = hd ? ytr_pkg::GV_709 : ytr_pkg::GV_601;
		bu     = hd ? ytr_pkg::BU_709 : ytr_pkg::BU_601;
		sum_r  = y_term + rv * e_ext + ytr_pkg::ROUND_HALF;
		sum_g  = y_term - gu * d_ext - gv * e_ext + ytr_pkg::ROUND_HALF;
		sum_b  = y_term + bu * d_ext + ytr_pkg::ROUND_HALF;
		rgb.red   = ytr_pkg::clamp_channel(sum_r);
		rgb.green = ytr_pkg::clamp_channel(sum_g);
		rgb.blue  = ytr_pkg::clamp_channel(sum_b);
	end
endmodule

>>> hw/rtl/yuyv_to_rgb_converter_core.sv
// Pipeline: input reg, then output reg; an accepted word is held in the input reg and
// moves to the output reg, offered as a result word, when that reg can advance.
// Throughput: one pixel-pair word per cycle; output reg stalls only on downstream ready.
// Frame length register is reloaded from the width and height registers.
// Reset (arst_n low, async): pipeline empty, pair count zero, width 640, height 480.
module yuyv_to_rgb_converter_core #(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ytr_stream_if.sink                    yuyv,
	ytr_stream_if.source                  rgb,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
	localparam int PROD_W = 2 * DIM_W;
	localparam int CNT_W  = $clog2((MAX_DIMENSION * MAX_DIMENSION + 1) / 2);
	localparam int LEN_W  = CNT_W + 1;
	localparam int RST_W  = (640 > MAX_DIMENSION) ? MAX_DIMENSION : 640;
	localparam int RST_H  = (480 > MAX_DIMENSION) ? MAX_DIMENSION : 480;
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'((RST_W * RST_H + 1) / 2);

	logic [ytr_pkg::CFG_W-1:0] width_q;
	logic [ytr_pkg::CFG_W-1:0] height_q;
	logic [LEN_W-1:0]          len_q;
	logic [CNT_W-1:0]          count_q;

	logic                      valid_s1;
	ytr_pkg::yuyv_word_t       word_s1;
	logic                      valid_q;
	ytr_pkg::rgb_word_t        out_q;

	logic                      cfg_wr;
	logic [DIM_W-1:0]          sat_w;
	logic [DIM_W-1:0]          sat_h;
	logic [PROD_W:0]           pixels;
	logic [LEN_W-1:0]          len_next;
	logic                      advance;
	logic                      hd;
	logic signed [8:0]         d;
	logic signed [8:0]         e;
	logic                      last;
	ytr_pkg::rgb_t             px_first;
	ytr_pkg::rgb_t             px_second;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (ytr_pkg::reg_idx_t'(paddr[2]))
			ytr_pkg::REG_FRAME_WIDTH:  prdata = 32'(width_q);
			ytr_pkg::REG_FRAME_HEIGHT: prdata = 32'(height_q);
			default:                   prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ytr_pkg::WIDTH_RESET;
			height_q <= ytr_pkg::HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (ytr_pkg::reg_idx_t'(paddr[2]))
				ytr_pkg::REG_FRAME_WIDTH:  width_q  <= pwdata[ytr_pkg::CFG_W-1:0];
				ytr_pkg::REG_FRAME_HEIGHT: height_q <= pwdata[ytr_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// frame length in pairs, dimensions saturated
	always_comb begin
		sat_w    = (32'(width_q) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION) : DIM_W'(width_q);
		sat_h    = (32'(height_q) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION) : DIM_W'(height_q);
		pixels   = (PROD_W + 1)'(sat_w) * (PROD_W + 1)'(sat_h) + (PROD_W + 1)'(1);
		len_next = LEN_W'(pixels >> 1);
		if (len_next == '0) begin
			len_next = LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else begin
			len_q <= len_next;
		end
	end

	assign advance    = !valid_q || rgb.ready;
	assign yuyv.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (yuyv.ready) begin
			valid_s1 <= yuyv.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (yuyv.valid && yuyv.ready) begin
			word_s1 <= yuyv.payload;
		end
	end

	assign hd   = (width_q >= ytr_pkg::HD_WIDTH) || (height_q >= ytr_pkg::HD_HEIGHT);
	assign d    = $signed({1'b0, word_s1.chroma_blue}) - ytr_pkg::CHROMA_MID;
	assign e    = $signed({1'b0, word_s1.chroma_red}) - ytr_pkg::CHROMA_MID;
	assign last = ({1'b0, count_q} + LEN_W'(1)) >= len_q;

	ytr_pixel u_px_first (
		.y    (word_s1.luma_first),
		.d    (d),
		.e    (e),
		.hd   (hd),
		.rgb  (px_first)
	);

	ytr_pixel u_px_second (
		.y    (word_s1.luma_second),
		.d    (d),
		.e    (e),
		.hd   (hd),
		.rgb  (px_second)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
		end else if (advance) begin
			valid_q <= valid_s1;
			if (valid_s1) begin
				count_q <= last ? '0 : count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q.red_first    <= px_first.red;
			out_q.green_first  <= px_first.green;
			out_q.blue_first   <= px_first.blue;
			out_q.red_second   <= px_second.red;
			out_q.green_second <= px_second.green;
			out_q.blue_second  <= px_second.blue;
			out_q.frame_end    <= last;
		end
	end

	assign rgb.valid   = valid_q;
	assign rgb.payload = out_q;
endmodule

>>> hw/rtl/ytr_checker.sv
`include "assert_macros.svh"

module ytr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input ytr_pkg::rgb_word_t out_word
);
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_word))
	`ASSERT_IMPLIES(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)
	`ASSERT_NEXT(a_two_cycle_flow, clk, arst_n, (in_valid && in_ready) ##1 out_ready, out_valid)
endmodule

bind yuyv_to_rgb_converter_core ytr_checker u_ytr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (yuyv.valid),
	.in_ready  (yuyv.ready),
	.out_valid (rgb.valid),
	.out_ready (rgb.ready),
	.out_word  (rgb.payload)
);

>>> tb/yuyv_to_rgb_converter_core_tb.sv
`timescale 1ns / 1ps

module yuyv_to_rgb_converter_core_tb;

	localparam int MAX_DIM = 4096;
	localparam int HD_W = 1280;
	localparam int HD_H = 720;
	localparam int LUMA_K = 298;
	localparam int LUMA_FLOOR = 16;
	localparam int CHROMA_CENTER = 128;
	localparam int ROUNDING = 128;
	localparam int RV_SD = 409;
	localparam int GU_SD = 100;
	localparam int GV_SD = 208;
	localparam int BU_SD = 516;
	localparam int RV_HD = 459;
	localparam int GU_HD = 55;
	localparam int GV_HD = 136;
	localparam int BU_HD = 541;
	localparam int NUM_SETTINGS = 12;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ytr_stream_if #(.payload_t(ytr_pkg::yuyv_word_t)) yuyv_ch ();
	ytr_stream_if #(.payload_t(ytr_pkg::rgb_word_t)) rgb_ch ();

	yuyv_to_rgb_converter_core #(
		.MAX_DIMENSION(MAX_DIM)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.yuyv(yuyv_ch),
		.rgb(rgb_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// converter state as predicted
	logic [12:0]     cfg_width;
	logic [12:0]     cfg_height;
	longint unsigned pairs_in_frame;

	ytr_pkg::yuyv_word_t yuyv_backlog[$];
	ytr_pkg::rgb_word_t  rgb_due[$];

	int  words_queued;
	int  words_sent;
	int  words_checked;
	int  frame_ends;
	int  settings_used;
	int  mismatches;
	int  src_gap;
	int  sink_stall;
	bit  calm;

	int unsigned set_w [NUM_SETTINGS] = '{3, 1280, 1, 1279, 0, 8191, 4096, 7, 2, 1, 4097, 640};
	int unsigned set_h [NUM_SETTINGS] = '{3, 0, 720, 719, 0, 8191, 1, 5, 2, 1, 1, 480};
	int unsigned set_n [NUM_SETTINGS] = '{150, 60, 370, 50, 30, 40, 40, 150, 60, 40, 30, 30};
	logic [7:0]  edge_bytes [12] = '{0, 1, 15, 16, 17, 127, 128, 129, 235, 240, 254, 255};
	string       chan_name [6] = '{"red_first", "green_first", "blue_first",
		"red_second", "green_second", "blue_second"};

	task automatic report(string msg);
		mismatches++;
		$display("MISMATCH: %s", msg);
	endtask

	function automatic logic [7:0] clip_channel(int sum);
		int q;
		if (sum < 0) begin
			return 8'd0;
		end
		q = sum >>> 8;
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	function automatic ytr_pkg::rgb_t pixel_to_rgb(logic [7:0] y, int d, int e, bit hd);
		int            rv;
		int            gu;
		int            gv;
		int            bu;
		int            c;
		ytr_pkg::rgb_t px;
		rv = hd ? RV_HD : RV_SD;
		gu = hd ? GU_HD : GU_SD;
		gv = hd ? GV_HD : GV_SD;
		bu = hd ? BU_HD : BU_SD;
		c = int'(y) - LUMA_FLOOR;
		if (c < 0) begin
			c = 0;
		end
		px.red   = clip_channel(LUMA_K * c + rv * e + ROUNDING);
		px.green = clip_channel(LUMA_K * c - gu * d - gv * e + ROUNDING);
		px.blue  = clip_channel(LUMA_K * c + bu * d + ROUNDING);
		return px;
	endfunction

	// one pair in, one word out; advances the pair count
	function automatic ytr_pkg::rgb_word_t convert_pair(ytr_pkg::yuyv_word_t w);
		bit                 hd;
		int                 d;
		int                 e;
		longint unsigned    wd;
		longint unsigned    ht;
		longint unsigned    span;
		ytr_pkg::rgb_t      p0;
		ytr_pkg::rgb_t      p1;
		ytr_pkg::rgb_word_t o;
		hd = (cfg_width >= HD_W) || (cfg_height >= HD_H);
		d = int'(w.chroma_blue) - CHROMA_CENTER;
		e = int'(w.chroma_red) - CHROMA_CENTER;
		wd = (cfg_width > MAX_DIM) ? MAX_DIM : cfg_width;
		ht = (cfg_height > MAX_DIM) ? MAX_DIM : cfg_height;
		span = (wd * ht + 1) >> 1;
		if (span == 0) begin
			span = 1;
		end
		p0 = pixel_to_rgb(w.luma_first, d, e, hd);
		p1 = pixel_to_rgb(w.luma_second, d, e, hd);
		o.red_first    = p0.red;
		o.green_first  = p0.green;
		o.blue_first   = p0.blue;
		o.red_second   = p1.red;
		o.green_second = p1.green;
		o.blue_second  = p1.blue;
		if (pairs_in_frame + 1 >= span) begin
			o.frame_end = 1'b1;
			pairs_in_frame = 0;
		end else begin
			o.frame_end = 1'b0;
			pairs_in_frame++;
		end
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 9) < 3) begin
			return edge_bytes[$urandom_range(0, 11)];
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic push_word(logic [7:0] y0, logic [7:0] u, logic [7:0] y1, logic [7:0] v);
		yuyv_backlog.push_back({y0, u, y1, v});
		words_queued++;
	endtask

	task automatic wait_idle();
		while (words_sent != words_queued || rgb_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(ytr_pkg::reg_idx_t idx, logic [12:0] value);
		logic [31:0] word_val;
		word_val = $urandom;
		word_val[12:0] = value;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word_val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == ytr_pkg::REG_FRAME_WIDTH) begin
			cfg_width = value;
		end else begin
			cfg_height = value;
		end
	endtask

	task automatic read_check(ytr_pkg::reg_idx_t idx, logic [12:0] want);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {19'd0, want}) begin
			report($sformatf("register %s read %0h, expected %0h", idx.name(), prdata, want));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// word source
	always @(posedge clk) begin
		if (!arst_n) begin
			yuyv_ch.valid <= 1'b0;
		end else begin
			if (yuyv_ch.valid && yuyv_ch.ready) begin
				rgb_due.push_back(convert_pair(yuyv_ch.payload));
				words_sent++;
			end
			if (!yuyv_ch.valid || yuyv_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					yuyv_ch.valid <= 1'b0;
				end else if (yuyv_backlog.size() != 0) begin
					yuyv_ch.payload <= yuyv_backlog.pop_front();
					yuyv_ch.valid   <= 1'b1;
					src_gap = pick_gap();
				end else begin
					yuyv_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result sink and checker
	always @(posedge clk) begin : rgb_sink
		ytr_pkg::rgb_word_t got;
		ytr_pkg::rgb_word_t want;
		if (!arst_n) begin
			rgb_ch.ready <= 1'b0;
		end else begin
			if (rgb_ch.valid && rgb_ch.ready) begin
				got = rgb_ch.payload;
				if (rgb_due.size() == 0) begin
					report($sformatf("result word %0h with nothing expected", got));
				end else begin
					want = rgb_due.pop_front();
					for (int k = 0; k < 6; k++) begin
						if (got[48-8*k -: 8] !== want[48-8*k -: 8]) begin
							report($sformatf("word %0d %s: got %0d, expected %0d",
								words_checked, chan_name[k], got[48-8*k -: 8],
								want[48-8*k -: 8]));
						end
					end
					if (got.frame_end !== want.frame_end) begin
						report($sformatf("word %0d frame_end: got %b, expected %b",
							words_checked, got.frame_end, want.frame_end));
					end
				end
				words_checked++;
				if (got.frame_end === 1'b1) begin
					frame_ends++;
				end
			end
			if (sink_stall > 0) begin
				sink_stall--;
				rgb_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				sink_stall = pick_gap();
				rgb_ch.ready <= 1'b0;
			end else begin
				rgb_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		#8_000_000;
		$display("run timed out with %0d words outstanding", rgb_due.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		yuyv_ch.valid   = 1'b0;
		yuyv_ch.payload = '0;
		rgb_ch.ready    = 1'b0;
		cfg_width       = 13'd640;
		cfg_height      = 13'd480;
		pairs_in_frame  = 0;
		calm            = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed pairs under reset settings
		push_word(8'd0, 8'd0, 8'd0, 8'd0);
		push_word(8'd255, 8'd255, 8'd255, 8'd255);
		push_word(8'd16, 8'd128, 8'd16, 8'd128);
		push_word(8'd15, 8'd128, 8'd17, 8'd128);
		push_word(8'd235, 8'd128, 8'd255, 8'd128);
		push_word(8'd255, 8'd0, 8'd0, 8'd255);
		push_word(8'd0, 8'd255, 8'd255, 8'd0);
		push_word(8'd128, 8'd0, 8'd128, 8'd0);
		push_word(8'd128, 8'd255, 8'd128, 8'd255);
		push_word(8'd81, 8'd90, 8'd145, 8'd240);
		push_word(8'd41, 8'd240, 8'd210, 8'd16);
		push_word(8'd17, 8'd127, 8'd254, 8'd129);
		push_word(8'd240, 8'd1, 8'd1, 8'd254);
		push_word(8'hAA, 8'h55, 8'h55, 8'hAA);
		push_word(8'h55, 8'hAA, 8'hAA, 8'h55);
		wait_idle();
		read_check(ytr_pkg::REG_FRAME_WIDTH, 13'd640);
		read_check(ytr_pkg::REG_FRAME_HEIGHT, 13'd480);

		// pair count carries across settings, so some phases start mid-frame
		for (int s = 0; s < NUM_SETTINGS; s++) begin
			wait_idle();
			write_reg(ytr_pkg::REG_FRAME_WIDTH, 13'(set_w[s]));
			write_reg(ytr_pkg::REG_FRAME_HEIGHT, 13'(set_h[s]));
			read_check(ytr_pkg::REG_FRAME_WIDTH, 13'(set_w[s]));
			read_check(ytr_pkg::REG_FRAME_HEIGHT, 13'(set_h[s]));
			settings_used++;
			calm = (s % 3 == 2);
			repeat (2) @(posedge clk);
			for (int n = 0; n < set_n[s]; n++) begin
				push_word(pick_byte(), pick_byte(), pick_byte(), pick_byte());
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (rgb_due.size() != 0) begin
			report($sformatf("%0d expected words never arrived", rgb_due.size()));
		end
		$display("%0d pixel pairs converted and checked, %0d frame ends, %0d register settings",
			words_checked, frame_ends, settings_used);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> yuyv_to_rgb_converter_core.f
+incdir+hw/rtl
hw/rtl/ytr_pkg.sv
hw/rtl/ytr_stream_if.sv
hw/rtl/ytr_pixel.sv
hw/rtl/yuyv_to_rgb_converter_core.sv
hw/rtl/ytr_checker.sv
tb/yuyv_to_rgb_converter_core_tb.sv
